[rtl/event_table_with_expiry_and_reminders_assert.svh]
// assertion macros shared by the event table rtl
// no dependencies; SYNTH removes the checks from synthesis builds
`ifndef EVENT_TABLE_WITH_EXPIRY_AND_REMINDERS_ASSERT_SVH
`define EVENT_TABLE_WITH_EXPIRY_AND_REMINDERS_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define EVTAB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("evtab assertion failed");
// next-cycle implication
`define EVTAB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("evtab assertion failed");
`else
`define EVTAB_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define EVTAB_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[rtl/evtab_pkg.sv]
// types, codes and sizes for the timed event table
// no dependencies
`default_nettype none

package evtab_pkg;

	localparam int NUM_SLOTS = 16;
	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int SLOT_W = 6;
	localparam int LEAD_W = 17;
	localparam logic [LEAD_W-1:0] LEAD_RESET = LEAD_W'(15 * 60);

	typedef enum logic [1:0] {
		MODE_ADD    = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_TICK   = 2'd2
	} mode_t;

	typedef enum logic [3:0] {
		KIND_NEW       = 4'd0,
		KIND_UPDATED   = 4'd1,
		KIND_REPLACED  = 4'd2,
		KIND_DROPPED   = 4'd3,
		KIND_REMOVED   = 4'd4,
		KIND_NOT_FOUND = 4'd5,
		KIND_EXPIRED   = 4'd6,
		KIND_REMINDER  = 4'd7,
		KIND_TICK_DONE = 4'd8
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [63:0] event_id;
		logic [31:0]        start_time;
		logic [31:0]        duration;
		logic               all_day;
		logic [31:0]        now;
	} in_item_t;

	typedef struct packed {
		kind_t              kind;
		logic [SLOT_W-1:0]  slot;
		logic signed [63:0] result_id;
		logic [31:0]        result_start;
		logic               last;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic step;
		logic emit_slot;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic is_tick;
		logic last_idx;
		logic slot_event;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

[rtl/event_table_with_expiry_and_reminders.sv]
// Timed event table with expiry and reminders, top level.
// Input channel (in_valid/in_stall/in_data) takes add, remove and tick items;
// output channel (out_valid/out_stall/out_data) returns result beats, the
// final beat of each item carrying last = 1. An item of the unused mode is
// taken and produces no beat.
// Each accepted item walks all NUM_SLOTS table slots in the datapath scan, one
// slot per cycle except where it pauses at a slot that waits for room in the
// output register. An add or remove gives one beat; a tick gives one beat per
// expired or reminded slot and a closing beat. The next item is accepted in
// the cycle after the previous item's final beat is loaded into the output
// register, even while that beat still waits.
// When out_stall is high the beat in the output register holds and the scan
// pauses at any slot that needs to emit, so no beat is lost.
// cfg_wr_en writes reminder_lead; write it only while the block is idle.
// arst_n empties the table, sets reminder_lead to 900 s and drops any
// pending beat.
`default_nettype none

module event_table_with_expiry_and_reminders (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire evtab_pkg::in_item_t          in_data,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output evtab_pkg::out_item_t              out_data,
	input  wire logic                         cfg_wr_en,
	input  wire logic [evtab_pkg::LEAD_W-1:0] cfg_wr_data
);
	import evtab_pkg::*;

	cmd_t cmd;
	sts_t sts;

	evtab_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_mode  (in_data.mode),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	evtab_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_data     (in_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

endmodule

`default_nettype wire

[rtl/evtab_ctrl.sv]
// sequencer for the event table: accept, slot scan, final result
// depends on evtab_pkg and the assertion header
`default_nettype none

module evtab_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic [1:0]    in_mode,
	output logic               in_stall,
	input  wire evtab_pkg::sts_t sts,
	output evtab_pkg::cmd_t    cmd
);
	import evtab_pkg::*;
	`include "event_table_with_expiry_and_reminders_assert.svh"

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					// the unused mode is taken and dropped
					if (in_mode == MODE_ADD || in_mode == MODE_REMOVE ||
							in_mode == MODE_TICK) begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (sts.is_tick && sts.slot_event) begin
					// a tick result waits for room in the output register
					if (sts.out_free) begin
						cmd.emit_slot = 1'b1;
						cmd.step = 1'b1;
					end
				end else begin
					cmd.step = 1'b1;
				end
				if (cmd.step && sts.last_idx) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`EVTAB_ASSERT_IMP(a_scan_hold_only_on_tick, clk, arst_n,
		(state_q == ST_SCAN) && !cmd.step, sts.is_tick && sts.slot_event && !sts.out_free)

endmodule

`default_nettype wire

[rtl/evtab_dp.sv]
// datapath of the event table: slot registers, scan accumulators, output register
// depends on evtab_pkg and the assertion header
`default_nettype none

module evtab_dp (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire evtab_pkg::in_item_t          in_data,
	input  wire logic                         cfg_wr_en,
	input  wire logic [evtab_pkg::LEAD_W-1:0] cfg_wr_data,
	input  wire evtab_pkg::cmd_t              cmd,
	output evtab_pkg::sts_t                   sts,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output evtab_pkg::out_item_t              out_data
);
	import evtab_pkg::*;
	`include "event_table_with_expiry_and_reminders_assert.svh"

	in_item_t in_q;
	logic [LEAD_W-1:0] lead_q;

	logic [NUM_SLOTS-1:0] used_q;
	logic signed [63:0]   id_q [NUM_SLOTS];
	logic [31:0]          start_q [NUM_SLOTS];
	logic [31:0]          dur_q [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] allday_q;
	logic [NUM_SLOTS-1:0] rem_q;

	logic [IDX_W-1:0] idx_q;
	logic             hit_q;
	logic [IDX_W-1:0] hit_slot_q;
	logic [31:0]      hit_start_q;
	logic             free_q;
	logic [IDX_W-1:0] free_slot_q;
	logic             lat_q;
	logic [IDX_W-1:0] lat_slot_q;
	logic [31:0]      lat_start_q;

	out_item_t out_q;
	logic      out_valid_q;

	logic               cur_used;
	logic signed [63:0] cur_id;
	logic [31:0]        cur_start;
	logic [32:0]        end_sum;
	logic [32:0]        lead_sum;
	logic               expired;
	logic               remind;
	logic               cur_hit;

	out_item_t        fin_item;
	logic             fin_write;
	logic             fin_clear;
	logic [IDX_W-1:0] fin_slot;
	logic             out_free;

	// current slot under the scan
	always_comb begin
		cur_used = used_q[idx_q];
		cur_id = id_q[idx_q];
		cur_start = start_q[idx_q];
		end_sum = {1'b0, cur_start} + {1'b0, dur_q[idx_q]};
		lead_sum = {1'b0, in_q.now} + 33'(lead_q);
		expired = {1'b0, in_q.now} > end_sum;
		remind = !allday_q[idx_q] && !rem_q[idx_q] && (lead_sum >= {1'b0, cur_start});
		cur_hit = cur_used && (cur_id == in_q.event_id);
	end

	// final result once the scan is through
	always_comb begin
		fin_item.kind = KIND_TICK_DONE;
		fin_item.slot = '0;
		fin_item.result_id = in_q.event_id;
		fin_item.result_start = in_q.start_time;
		fin_item.last = 1'b1;
		fin_write = 1'b0;
		fin_clear = 1'b0;
		fin_slot = hit_slot_q;
		case (in_q.mode)
			MODE_ADD: begin
				if (hit_q) begin
					fin_item.kind = KIND_UPDATED;
					fin_write = 1'b1;
				end else if (free_q) begin
					fin_item.kind = KIND_NEW;
					fin_slot = free_slot_q;
					fin_write = 1'b1;
				end else if (lat_q && (lat_start_q > in_q.start_time)) begin
					fin_item.kind = KIND_REPLACED;
					fin_slot = lat_slot_q;
					fin_write = 1'b1;
				end else begin
					fin_item.kind = KIND_DROPPED;
				end
				if (fin_write) begin
					fin_item.slot = SLOT_W'(fin_slot);
				end
			end
			MODE_REMOVE: begin
				if (hit_q) begin
					fin_item.kind = KIND_REMOVED;
					fin_item.slot = SLOT_W'(hit_slot_q);
					fin_item.result_start = hit_start_q;
					fin_clear = 1'b1;
				end else begin
					fin_item.kind = KIND_NOT_FOUND;
					fin_item.result_start = '0;
				end
			end
			default: begin
				fin_item.result_id = '0;
				fin_item.result_start = '0;
			end
		endcase
	end

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		sts.is_tick = (in_q.mode == MODE_TICK);
		sts.last_idx = (idx_q == IDX_W'(NUM_SLOTS - 1));
		sts.slot_event = cur_used && (expired || remind);
		sts.out_free = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q <= LEAD_RESET;
			used_q <= '0;
			idx_q <= '0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
			lat_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				lead_q <= cfg_wr_data;
			end
			if (cmd.load) begin
				idx_q <= '0;
				hit_q <= 1'b0;
				free_q <= 1'b0;
				lat_q <= 1'b0;
			end else if (cmd.step) begin
				idx_q <= idx_q + 1'b1;
				if (cur_hit) begin
					hit_q <= 1'b1;
				end
				if (!cur_used) begin
					free_q <= 1'b1;
				end
				if (cur_used) begin
					lat_q <= 1'b1;
				end
			end
			if (cmd.emit_slot && expired) begin
				used_q[idx_q] <= 1'b0;
			end
			if (cmd.finish && fin_write) begin
				used_q[fin_slot] <= 1'b1;
			end
			if (cmd.finish && fin_clear) begin
				used_q[fin_slot] <= 1'b0;
			end
			if (cmd.emit_slot || cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q <= in_data;
		end
		if (cmd.step) begin
			// first match and first free slot only
			if (cur_hit && !hit_q) begin
				hit_slot_q <= idx_q;
				hit_start_q <= cur_start;
			end
			if (!cur_used && !free_q) begin
				free_slot_q <= idx_q;
			end
			// strict compare keeps the lowest slot on ties
			if (cur_used && (!lat_q || (cur_start > lat_start_q))) begin
				lat_slot_q <= idx_q;
				lat_start_q <= cur_start;
			end
		end
		if (cmd.emit_slot && !expired) begin
			rem_q[idx_q] <= 1'b1;
		end
		if (cmd.finish && fin_write) begin
			id_q[fin_slot] <= in_q.event_id;
			start_q[fin_slot] <= in_q.start_time;
			dur_q[fin_slot] <= in_q.duration;
			allday_q[fin_slot] <= in_q.all_day;
			rem_q[fin_slot] <= (in_q.now >= in_q.start_time);
		end
		if (cmd.emit_slot) begin
			out_q.kind <= expired ? KIND_EXPIRED : KIND_REMINDER;
			out_q.slot <= SLOT_W'(idx_q);
			out_q.result_id <= cur_id;
			out_q.result_start <= cur_start;
			out_q.last <= 1'b0;
		end else if (cmd.finish) begin
			out_q <= fin_item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	`EVTAB_ASSERT_IMP(a_load_only_when_free, clk, arst_n,
		cmd.emit_slot || cmd.finish, out_free)
	`EVTAB_ASSERT_NXT(a_tick_beat_not_last, clk, arst_n,
		cmd.emit_slot, out_valid_q && !out_q.last &&
		(out_q.kind == KIND_EXPIRED || out_q.kind == KIND_REMINDER))

endmodule

`default_nettype wire

[tb/sv/evtab_checker.sv]
// result checker for the timed event table: keeps a mirror of the slot table,
// predicts every beat of each accepted item and compares field by field
// depends on evtab_pkg
module evtab_checker
	import evtab_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  in_item_t          in_data,
	input  logic              out_valid,
	input  logic              out_stall,
	input  out_item_t         out_data,
	input  logic              cfg_wr_en,
	input  logic [LEAD_W-1:0] cfg_wr_data,
	output int                mismatches,
	output int                results_waiting,
	output int                results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	logic              tab_used     [NUM_SLOTS];
	logic [63:0]       tab_id       [NUM_SLOTS];
	logic [31:0]       tab_start    [NUM_SLOTS];
	logic [31:0]       tab_duration [NUM_SLOTS];
	logic              tab_all_day  [NUM_SLOTS];
	logic              tab_reminded [NUM_SLOTS];
	logic [LEAD_W-1:0] lead;
	out_item_t         pending_results [$];
	int                fail_total = 0;
	int                seen_total = 0;

	initial begin
		mismatches = 0;
		results_waiting = 0;
		results_seen = 0;
	end

	task automatic queue_result(kind_t kind, int s, logic [63:0] id, logic [31:0] start,
			logic last);
		out_item_t r;
		r.kind = kind;
		r.slot = SLOT_W'(s);
		r.result_id = id;
		r.result_start = start;
		r.last = last;
		pending_results.push_back(r);
	endtask

	task automatic apply_table_op(in_item_t it);
		int          hit;
		int          free_slot;
		int          latest;
		int          s;
		kind_t       kind;
		logic [32:0] expiry;
		logic [32:0] reach;
		hit = -1;
		free_slot = -1;
		latest = -1;
		case (it.mode)
		MODE_ADD: begin
			for (s = 0; s < NUM_SLOTS; s++) begin
				if (hit < 0 && tab_used[s] && tab_id[s] == it.event_id)
					hit = s;
				// latest start is only tracked up to the first free slot
				if (free_slot < 0) begin
					if (!tab_used[s])
						free_slot = s;
					else if (latest < 0 || tab_start[s] > tab_start[latest])
						latest = s;
				end
			end
			s = 0;
			if (hit >= 0) begin
				kind = KIND_UPDATED;
				s = hit;
			end else if (free_slot >= 0) begin
				kind = KIND_NEW;
				s = free_slot;
			end else if (tab_start[latest] > it.start_time) begin
				kind = KIND_REPLACED;
				s = latest;
			end else begin
				kind = KIND_DROPPED;
			end
			if (kind == KIND_DROPPED) begin
				queue_result(KIND_DROPPED, 0, it.event_id, it.start_time, 1'b1);
			end else begin
				tab_used[s] = 1'b1;
				tab_id[s] = it.event_id;
				tab_start[s] = it.start_time;
				tab_duration[s] = it.duration;
				tab_all_day[s] = it.all_day;
				tab_reminded[s] = it.now >= it.start_time;
				queue_result(kind, s, it.event_id, it.start_time, 1'b1);
			end
		end
		MODE_REMOVE: begin
			for (s = 0; s < NUM_SLOTS; s++)
				if (hit < 0 && tab_used[s] && tab_id[s] == it.event_id)
					hit = s;
			if (hit < 0) begin
				queue_result(KIND_NOT_FOUND, 0, it.event_id, '0, 1'b1);
			end else begin
				tab_used[hit] = 1'b0;
				queue_result(KIND_REMOVED, hit, it.event_id, tab_start[hit], 1'b1);
			end
		end
		MODE_TICK: begin
			reach = {1'b0, it.now} + 33'(lead);
			for (s = 0; s < NUM_SLOTS; s++) begin
				if (tab_used[s]) begin
					// end of event at 33 bits so a late start cannot wrap
					expiry = {1'b0, tab_start[s]} + {1'b0, tab_duration[s]};
					if ({1'b0, it.now} > expiry) begin
						tab_used[s] = 1'b0;
						queue_result(KIND_EXPIRED, s, tab_id[s], tab_start[s], 1'b0);
					end else if (!tab_all_day[s] && !tab_reminded[s] &&
							reach >= {1'b0, tab_start[s]}) begin
						tab_reminded[s] = 1'b1;
						queue_result(KIND_REMINDER, s, tab_id[s], tab_start[s], 1'b0);
					end
				end
			end
			queue_result(KIND_TICK_DONE, 0, '0, '0, 1'b1);
		end
		default: ; // unused mode: no beat, table untouched
		endcase
	endtask

	task automatic check_result(out_item_t got);
		out_item_t want;
		seen_total++;
		if (pending_results.size() == 0) begin
			fail_total++;
			$display("%0t: unexpected beat, kind=%0d slot=%0d id=%h start=%h last=%b",
				$time, got.kind, got.slot, got.result_id, got.result_start, got.last);
		end else begin
			want = pending_results.pop_front();
			if (got.kind !== want.kind || got.slot !== want.slot ||
					got.result_id !== want.result_id ||
					got.result_start !== want.result_start || got.last !== want.last) begin
				fail_total++;
				$display("%0t: mismatch, expected kind=%0d slot=%0d id=%h start=%h last=%b",
					$time, want.kind, want.slot, want.result_id, want.result_start,
					want.last);
				$display("%0t:           actual kind=%0d slot=%0d id=%h start=%h last=%b",
					$time, got.kind, got.slot, got.result_id, got.result_start, got.last);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NUM_SLOTS; s++) begin
				tab_used[s] = 1'b0;
				tab_id[s] = '0;
				tab_start[s] = '0;
				tab_duration[s] = '0;
				tab_all_day[s] = 1'b0;
				tab_reminded[s] = 1'b0;
			end
			lead = LEAD_RESET;
			pending_results.delete();
		end else begin
			// older beats are checked before the new item's beats are queued
			if (out_valid && !out_stall)
				check_result(out_data);
			if (in_valid && !in_stall)
				apply_table_op(in_data);
			if (cfg_wr_en)
				lead = cfg_wr_data;
		end
		mismatches <= fail_total;
		results_waiting <= pending_results.size();
		results_seen <= seen_total;
	end

endmodule

[tb/sv/tb.sv]
// top of the event table testbench: clock, reset, stall pattern and stimulus
// (directed table fill, then random phases at several reminder leads)
// depends on evtab_pkg, evtab_checker and event_table_with_expiry_and_reminders
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import evtab_pkg::*;

	localparam int                CLK_PERIOD    = 10;
	localparam int                RESET_CYCLES  = 9;
	localparam int                SETTLE_CYCLES = NUM_SLOTS + 8;
	localparam int                QUIET_LIMIT   = 2000;
	localparam int                POOL_SIZE     = 24;
	localparam int                PHASE_ITEMS   = 52;
	localparam int                NUM_PHASES    = 4;
	localparam logic [1:0]        MODE_UNUSED   = 2'd3;
	localparam logic [LEAD_W-1:0] LEAD_MAX      = {LEAD_W{1'b1}};
	localparam logic [LEAD_W-1:0] LEAD_DAY      = LEAD_W'(86400);
	localparam logic [63:0]       ID_MAX        = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0]       ID_MIN        = 64'h8000_0000_0000_0000;

	typedef enum {STALL_NONE, STALL_RANDOM, STALL_RUNS, STALL_TOGGLE} stall_style_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	in_item_t          in_data = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	out_item_t         out_data;
	logic              cfg_wr_en = 1'b0;
	logic [LEAD_W-1:0] cfg_wr_data = '0;
	int                mismatches;
	int                results_waiting;
	int                results_seen;

	stall_style_t      stall_style = STALL_NONE;
	int                style_left = 0;
	int                stall_run = 0;
	int                quiet_cycles = 0;
	int                burst_left = 0;
	int                items_sent = 0;
	int unsigned       wall;
	logic [63:0]       id_pool [POOL_SIZE];

	always #(CLK_PERIOD / 2) clk = ~clk;

	event_table_with_expiry_and_reminders i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	evtab_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.in_data         (in_data),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_data        (out_data),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.mismatches      (mismatches),
		.results_waiting (results_waiting),
		.results_seen    (results_seen)
	);

	// receiver back-pressure, switching between stall styles at random
	always @(posedge clk) begin
		if (style_left == 0) begin
			stall_style <= stall_style_t'($urandom_range(0, 3));
			style_left <= $urandom_range(50, 300);
		end else begin
			style_left <= style_left - 1;
		end
		case (stall_style)
		STALL_NONE: out_stall <= 1'b0;
		STALL_RANDOM: out_stall <= ($urandom_range(0, 3) == 0);
		STALL_RUNS: begin
			if (stall_run != 0) begin
				out_stall <= 1'b1;
				stall_run <= stall_run - 1;
			end else begin
				out_stall <= 1'b0;
				if ($urandom_range(0, 9) == 0)
					stall_run <= $urandom_range(1, 8);
			end
		end
		default: out_stall <= ~out_stall;
		endcase
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic in_item_t make_op(logic [1:0] mode, logic [63:0] id,
			logic [31:0] start, logic [31:0] dur, logic all_day, logic [31:0] now);
		in_item_t it;
		it.mode = mode;
		it.event_id = id;
		it.start_time = start;
		it.duration = dur;
		it.all_day = all_day;
		it.now = now;
		return it;
	endfunction

	// mostly pooled ids and starts near the running wall clock so that updates,
	// removes, reminders and expiries actually hit; long_lived lets the table fill
	function automatic in_item_t random_op(bit long_lived);
		in_item_t    it;
		int unsigned pick;
		it.event_id = {$urandom, $urandom};
		it.start_time = $urandom;
		it.duration = $urandom;
		it.all_day = $urandom_range(0, 1);
		it.now = $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 4)
			it.mode = MODE_UNUSED;
		else if (pick < 48)
			it.mode = MODE_ADD;
		else if (pick < (long_lived ? 58 : 70))
			it.mode = MODE_REMOVE;
		else
			it.mode = MODE_TICK;
		if ($urandom_range(0, 99) < 85)
			it.event_id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
		case (it.mode)
		MODE_ADD: begin
			if ($urandom_range(0, 4) != 0)
				it.start_time = wall + $urandom_range(0, 4000) - 1000;
			if (long_lived) begin
				it.duration = $urandom_range(100_000, 3_000_000);
			end else begin
				case ($urandom_range(0, 5))
				0: it.duration = '0;
				1: ;
				default: it.duration = $urandom_range(0, 3000);
				endcase
			end
			it.all_day = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 9) != 0)
				it.now = wall;
		end
		MODE_TICK: begin
			if ($urandom_range(0, 19) != 0) begin
				wall = wall + $urandom_range(0, long_lived ? 200 : 700);
				it.now = wall;
			end
		end
		default: ;
		endcase
		return it;
	endfunction

	task automatic send_op(in_item_t it);
		in_data <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
	endtask

	// bursts of random length with random gaps in between
	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			burst_left = $urandom_range(0, 20);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// hold off until every expected beat is back and the scan has wound down
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_waiting != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_lead(logic [LEAD_W-1:0] value);
		cfg_wr_data <= value;
		cfg_wr_en <= 1'b1;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		int                k;
		int                phase;
		logic [LEAD_W-1:0] rand_lead;
		id_pool[0] = ID_MAX;
		id_pool[1] = ID_MIN;
		id_pool[2] = '0;
		id_pool[3] = '1;
		for (k = 4; k < POOL_SIZE; k++)
			id_pool[k] = {$urandom, $urandom};
		wall = $urandom_range(32'h0100_0000, 32'h7000_0000);
		rand_lead = LEAD_W'($urandom_range(1, 131070));

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table: bare tick, then a remove that misses
		send_op(make_op(MODE_TICK, '0, '0, '0, 1'b0, 32'd100));
		pace();
		send_op(make_op(MODE_REMOVE, ID_MIN, '1, '1, 1'b1, '0));
		pace();
		// fill every slot: extreme ids, two all-day entries, a start near the top
		// whose end only fits in 33 bits, one already reminded when added
		for (k = 0; k < NUM_SLOTS; k++) begin
			send_op(make_op(MODE_ADD, id_pool[k],
				(k == 1) ? 32'hFFFF_FFFF : (k == 2) ? 32'hFFFF_FFF0 : 32'(2000 + 300 * k),
				(k <= 2) ? 32'hFFFF_FFFF : (k % 4 == 0) ? 32'd0 : 32'd500,
				k == 1 || k == 3, (k == 1) ? 32'hFFFF_FFFF : 32'd0));
			pace();
		end
		// full table: equal latest start drops, an earlier start replaces it
		send_op(make_op(MODE_ADD, id_pool[NUM_SLOTS], 32'hFFFF_FFFF, 32'd100, 1'b0, '0));
		pace();
		send_op(make_op(MODE_ADD, id_pool[NUM_SLOTS + 1], 32'd10, 32'd5, 1'b0, '0));
		pace();
		send_op(make_op(MODE_ADD, ID_MAX, 32'd3000, 32'd0, 1'b0, 32'd3000));
		pace();
		send_op(make_op(MODE_TICK, '1, '1, '1, 1'b1, 32'd2500));
		pace();
		send_op(make_op(MODE_TICK, '0, '0, '0, 1'b0, 32'd3300));
		pace();
		send_op(make_op(MODE_REMOVE, id_pool[3], '0, '0, 1'b0, '1));
		pace();
		send_op(make_op(MODE_UNUSED, {$urandom, $urandom}, $urandom, $urandom, 1'b1,
			$urandom));
		pace();
		send_op(make_op(MODE_TICK, '0, '0, '0, 1'b0, 32'hFFFF_FFFF));
		pace();

		for (phase = 0; phase < NUM_PHASES; phase++) begin
			settle();
			case (phase)
			0: write_lead('0);
			1: write_lead(LEAD_MAX);
			2: write_lead(LEAD_DAY);
			default: write_lead(rand_lead);
			endcase
			for (k = 0; k < PHASE_ITEMS; k++) begin
				send_op(random_op(phase % 2 == 1));
				pace();
				if ($urandom_range(0, 39) == 0)
					settle();
			end
		end
		settle();

		$display("%0d items sent to a %0d-slot table, %0d result beats compared",
			items_sent, NUM_SLOTS, results_seen);
		$display("reminder lead at reset value, 0, %0d, %0d and %0d; full-table drops and replacements included",
			LEAD_MAX, LEAD_DAY, rand_lead);
		if (mismatches == 0 && results_waiting == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
